// ===== rtl/usbsx_pkg.sv =====
// ----------------------------------------------------------------------------
// usbsx_pkg
// Shared types and constants for the USB-MIDI SysEx reassembler.
// ----------------------------------------------------------------------------
`default_nettype none

package usbsx_pkg;

  localparam int unsigned CountW  = 16;
  localparam int unsigned LenW    = 16;
  localparam logic [LenW-1:0] MaxLenReset = 16'd256;

  localparam logic [3:0] CinSysexCont = 4'h4;
  localparam logic [3:0] CinSysexEnd1 = 4'h5;
  localparam logic [3:0] CinSysexEnd2 = 4'h6;
  localparam logic [3:0] CinSysexEnd3 = 4'h7;
  localparam logic [3:0] CinCtrlChg   = 4'hB;
  localparam logic [3:0] CinSingle    = 4'hF;

  localparam logic [7:0] MidiSox      = 8'hF0;
  localparam logic [7:0] MidiEox      = 8'hF7;
  localparam logic [3:0] MidiCcNibble = 4'hB;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_BYTES    = 3'd1,
    EV_END      = 3'd2,
    EV_CC       = 3'd3,
    EV_INVALID  = 3'd4,
    EV_OVERFLOW = 3'd5,
    EV_REJECTED = 3'd6
  } event_t;

  typedef struct packed {
    event_t     ev;
    logic [1:0] cnt;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } result_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              sox;
  } asm_state_t;

endpackage

`default_nettype wire

// ===== rtl/usbsx_decode.sv =====
// ----------------------------------------------------------------------------
// usbsx_decode
// Decodes one event packet against the assembly state; gives the result
// and the next assembly state.
// ----------------------------------------------------------------------------
`default_nettype none

module usbsx_decode (
  input  wire logic [3:0]                   cin,
  input  wire logic [7:0]                   b1,
  input  wire logic [7:0]                   b2,
  input  wire logic [7:0]                   b3,
  input  wire logic [usbsx_pkg::LenW-1:0]   max_len,
  input  wire usbsx_pkg::asm_state_t        cur,
  output usbsx_pkg::result_t                res,
  output usbsx_pkg::asm_state_t             nxt
);

  logic [usbsx_pkg::CountW:0] sum1;
  logic [usbsx_pkg::CountW:0] sum2;
  logic [usbsx_pkg::CountW:0] sum3;
  logic [usbsx_pkg::CountW:0] max_ext;
  logic                       cnt_gt2;
  logic [1:0]                 n;
  logic [7:0]                 last;
  logic [usbsx_pkg::CountW:0] sum_n;
  usbsx_pkg::event_t          ev;

  assign sum1    = {1'b0, cur.count} + 17'd1;
  assign sum2    = {1'b0, cur.count} + 17'd2;
  assign sum3    = {1'b0, cur.count} + 17'd3;
  assign max_ext = {1'b0, max_len};
  assign cnt_gt2 = (cur.count > 16'd2);

  always_comb begin
    n   = 2'd0;
    ev  = usbsx_pkg::EV_NONE;
    nxt = cur;
    last  = b1;
    sum_n = sum1;
    case (cin)
      usbsx_pkg::CinSingle: begin
        if (b1 == usbsx_pkg::MidiEox && cnt_gt2) begin
          nxt = '0;
          if (sum1 > max_ext) begin
            ev = usbsx_pkg::EV_OVERFLOW;
          end else begin
            ev = usbsx_pkg::EV_END;
            n  = 2'd1;
          end
        end else if (b1[7]) begin
          ev = usbsx_pkg::EV_NONE;
        end else if (cnt_gt2) begin
          if (sum1 > max_ext) begin
            nxt = '0;
            ev  = usbsx_pkg::EV_OVERFLOW;
          end else begin
            nxt.count = sum1[usbsx_pkg::CountW-1:0];
            ev = usbsx_pkg::EV_BYTES;
            n  = 2'd1;
          end
        end else begin
          nxt = '0;
          ev  = usbsx_pkg::EV_REJECTED;
        end
      end
      usbsx_pkg::CinSysexEnd1, usbsx_pkg::CinSysexEnd2, usbsx_pkg::CinSysexEnd3: begin
        if (cin == usbsx_pkg::CinSysexEnd1) begin
          n = 2'd1; last = b1; sum_n = sum1;
        end else if (cin == usbsx_pkg::CinSysexEnd2) begin
          n = 2'd2; last = b2; sum_n = sum2;
        end else begin
          n = 2'd3; last = b3; sum_n = sum3;
        end
        nxt = '0;
        if (!cnt_gt2 || !cur.sox || last != usbsx_pkg::MidiEox) begin
          ev = usbsx_pkg::EV_INVALID;
          n  = 2'd0;
        end else if (sum_n > max_ext) begin
          ev = usbsx_pkg::EV_OVERFLOW;
          n  = 2'd0;
        end else begin
          ev = usbsx_pkg::EV_END;
        end
      end
      usbsx_pkg::CinSysexCont: begin
        if (sum3 > max_ext) begin
          nxt = '0;
          ev  = usbsx_pkg::EV_OVERFLOW;
        end else begin
          if (cur.count == '0) begin
            nxt.sox = (b1 == usbsx_pkg::MidiSox);
          end
          nxt.count = sum3[usbsx_pkg::CountW-1:0];
          ev = usbsx_pkg::EV_BYTES;
          n  = 2'd3;
        end
      end
      usbsx_pkg::CinCtrlChg: begin
        if (b1[7:4] != usbsx_pkg::MidiCcNibble) begin
          nxt = '0;
          ev  = usbsx_pkg::EV_REJECTED;
        end else begin
          ev = usbsx_pkg::EV_CC;
          n  = 2'd3;
        end
      end
      default: begin
        ev = usbsx_pkg::EV_NONE;
      end
    endcase
  end

  assign res.ev  = ev;
  assign res.cnt = n;
  assign res.b1  = (n > 2'd0) ? b1 : 8'd0;
  assign res.b2  = (n > 2'd1) ? b2 : 8'd0;
  assign res.b3  = (n > 2'd2) ? b3 : 8'd0;

endmodule

`default_nettype wire

// ===== rtl/usb_midi_sysex_reassembler.sv =====
// ----------------------------------------------------------------------------
// usb_midi_sysex_reassembler
// The result is registered and is valid in the cycle after the input transfer.
// Throughput: one packet per cycle while the input is not stalled; the result register is the only stage.
// Input stalls only while a result is held and the output is stalled.
// Reset (rst_n low, synchronous) clears the count, start flag and result
// valid, and sets the length limit to MAX_LEN_RESET (256 by default).
// ----------------------------------------------------------------------------
`default_nettype none

module usb_midi_sysex_reassembler #(
  parameter logic [usbsx_pkg::LenW-1:0] MAX_LEN_RESET = usbsx_pkg::MaxLenReset
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_valid,
  output      logic                       cfg_ready,
  input  wire logic [usbsx_pkg::LenW-1:0] cfg_data,
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire logic [7:0]                 in_packet_header,
  input  wire logic [7:0]                 in_midi_byte_one,
  input  wire logic [7:0]                 in_midi_byte_two,
  input  wire logic [7:0]                 in_midi_byte_three,
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      logic [2:0]                 out_event_res,
  output      logic [1:0]                 out_byte_count,
  output      logic [7:0]                 out_byte_one,
  output      logic [7:0]                 out_byte_two,
  output      logic [7:0]                 out_byte_three
);

  logic [usbsx_pkg::LenW-1:0] max_len_r;
  usbsx_pkg::asm_state_t      state_r;
  usbsx_pkg::asm_state_t      state_nxt;
  usbsx_pkg::result_t         res_r;
  usbsx_pkg::result_t         res_nxt;
  logic                       out_valid_r;
  logic                       in_xfer;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_xfer   = in_valid && !in_stall;

  usbsx_decode u_decode (
    .cin     (in_packet_header[3:0]),
    .b1      (in_midi_byte_one),
    .b2      (in_midi_byte_two),
    .b3      (in_midi_byte_three),
    .max_len (max_len_r),
    .cur     (state_r),
    .res     (res_nxt),
    .nxt     (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= MAX_LEN_RESET;
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_len_r <= cfg_data;
      end
      if (in_xfer) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold result while stalled
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_res  = res_r.ev;
  assign out_byte_count = res_r.cnt;
  assign out_byte_one   = res_r.b1;
  assign out_byte_two   = res_r.b2;
  assign out_byte_three = res_r.b3;

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with no result held");

  a_error_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.ev == usbsx_pkg::EV_INVALID ||
                     res_r.ev == usbsx_pkg::EV_OVERFLOW ||
                     res_r.ev == usbsx_pkg::EV_REJECTED)) |-> (res_r.cnt == 2'd0))
    else $error("error result carries bytes");

  a_error_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (res_nxt.ev == usbsx_pkg::EV_INVALID ||
                 res_nxt.ev == usbsx_pkg::EV_OVERFLOW ||
                 res_nxt.ev == usbsx_pkg::EV_REJECTED ||
                 res_nxt.ev == usbsx_pkg::EV_END)) |=> (state_r == '0))
    else $error("assembly state not cleared after message end or error");

  a_count_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && res_nxt.ev == usbsx_pkg::EV_BYTES) |=>
      (state_r.count <= max_len_r))
    else $error("byte count passed the length limit");

endmodule

`default_nettype wire

// ===== test/tb_usb_midi_sysex_reassembler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_usb_midi_sysex_reassembler
// Drives USB-MIDI event packets into the reassembler and predicts every result
// from a behavioral copy of its count, start flag and length limit. The test
// covers directed corner cases, overflow at several limits, and random
// messages mixed with noise. Random gaps, receiver stalls and one long output
// hold are used to exercise the valid/stall handshakes.
// ----------------------------------------------------------------------------
module tb_usb_midi_sysex_reassembler;
  import usbsx_pkg::*;

  typedef struct {
    logic [7:0]  hdr;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    int unsigned gap;
  } packet_t;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [LenW-1:0] cfg_data  = '0;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  logic [7:0]      in_packet_header   = '0;
  logic [7:0]      in_midi_byte_one   = '0;
  logic [7:0]      in_midi_byte_two   = '0;
  logic [7:0]      in_midi_byte_three = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [2:0]      out_event_res;
  logic [1:0]      out_byte_count;
  logic [7:0]      out_byte_one;
  logic [7:0]      out_byte_two;
  logic [7:0]      out_byte_three;

  packet_t packet_queue[$];
  result_t awaited_results[$];

  logic [LenW-1:0]   limit_shadow  = MaxLenReset;
  logic [CountW-1:0] sysex_count   = '0;
  logic              sysex_started = 1'b0;

  int          errors      = 0;
  int unsigned items_pushed = 0;
  int unsigned gap_max     = 7;
  int unsigned stall_max   = 7;
  int unsigned hold_asks   = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;
  int unsigned stall_left  = 0;
  int unsigned gap_left    = 0;
  bit          staged      = 1'b0;
  bit          in_xfer     = 1'b0;
  bit          out_xfer    = 1'b0;
  packet_t     stage;

  usb_midi_sysex_reassembler uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_packet_header   (in_packet_header),
    .in_midi_byte_one   (in_midi_byte_one),
    .in_midi_byte_two   (in_midi_byte_two),
    .in_midi_byte_three (in_midi_byte_three),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_res      (out_event_res),
    .out_byte_count     (out_byte_count),
    .out_byte_one       (out_byte_one),
    .out_byte_two       (out_byte_two),
    .out_byte_three     (out_byte_three)
  );

  always #1 clk = ~clk;

  function automatic void drop_message();
    sysex_count   = '0;
    sysex_started = 1'b0;
  endfunction

  function automatic result_t decode_packet(input packet_t p);
    result_t    r;
    int         cnt;
    int         n;
    logic [7:0] last;
    bit         ok;
    r   = '0;
    cnt = int'(sysex_count);
    case (p.hdr[3:0])
      CinSingle: begin
        if (p.b1 == MidiEox && cnt > 2) begin
          ok = (cnt + 1 <= int'(limit_shadow));
          drop_message();
          if (ok) begin
            r.ev  = EV_END;
            r.cnt = 2'd1;
            r.b1  = p.b1;
          end else begin
            r.ev = EV_OVERFLOW;
          end
        end else if (p.b1[7]) begin
          r.ev = EV_NONE;
        end else if (cnt > 2) begin
          if (cnt + 1 > int'(limit_shadow)) begin
            drop_message();
            r.ev = EV_OVERFLOW;
          end else begin
            sysex_count = sysex_count + 16'd1;
            r.ev  = EV_BYTES;
            r.cnt = 2'd1;
            r.b1  = p.b1;
          end
        end else begin
          drop_message();
          r.ev = EV_REJECTED;
        end
      end
      CinSysexEnd1, CinSysexEnd2, CinSysexEnd3: begin
        n    = (p.hdr[3:0] == CinSysexEnd1) ? 1 : (p.hdr[3:0] == CinSysexEnd2) ? 2 : 3;
        last = (n == 1) ? p.b1 : (n == 2) ? p.b2 : p.b3;
        if (cnt < 3 || !sysex_started || last != MidiEox) begin
          r.ev = EV_INVALID;
        end else if (cnt + n > int'(limit_shadow)) begin
          r.ev = EV_OVERFLOW;
        end else begin
          r.ev  = EV_END;
          r.cnt = 2'(n);
          r.b1  = p.b1;
          if (n > 1) r.b2 = p.b2;
          if (n > 2) r.b3 = p.b3;
        end
        drop_message();
      end
      CinSysexCont: begin
        if (cnt + 3 > int'(limit_shadow)) begin
          drop_message();
          r.ev = EV_OVERFLOW;
        end else begin
          if (cnt == 0) sysex_started = (p.b1 == MidiSox);
          sysex_count = sysex_count + 16'd3;
          r.ev  = EV_BYTES;
          r.cnt = 2'd3;
          r.b1  = p.b1;
          r.b2  = p.b2;
          r.b3  = p.b3;
        end
      end
      CinCtrlChg: begin
        if (p.b1[7:4] != MidiCcNibble) begin
          drop_message();
          r.ev = EV_REJECTED;
        end else begin
          r.ev  = EV_CC;
          r.cnt = 2'd3;
          r.b1  = p.b1;
          r.b2  = p.b2;
          r.b3  = p.b3;
        end
      end
      default: r.ev = EV_NONE;
    endcase
    return r;
  endfunction

  // Input side: track limit writes and predict each packet transfer.
  always @(posedge clk) begin : packet_accept
    packet_t p;
    in_xfer <= rst_n && in_valid && !in_stall;
    if (rst_n && cfg_valid && cfg_ready) limit_shadow = cfg_data;
    if (rst_n && in_valid && !in_stall) begin
      p.hdr = in_packet_header;
      p.b1  = in_midi_byte_one;
      p.b2  = in_midi_byte_two;
      p.b3  = in_midi_byte_three;
      p.gap = 0;
      awaited_results.push_back(decode_packet(p));
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_xfer)) begin
      if (!staged && packet_queue.size() > 0) begin
        stage    = packet_queue.pop_front();
        staged   = 1'b1;
        gap_left = stage.gap;
      end
      if (staged && gap_left == 0) begin
        in_packet_header   <= stage.hdr;
        in_midi_byte_one   <= stage.b1;
        in_midi_byte_two   <= stage.b2;
        in_midi_byte_three <= stage.b3;
        in_valid           <= 1'b1;
        staged = 1'b0;
      end else begin
        in_valid <= 1'b0;
        if (staged) gap_left--;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_asks != hold_served) begin
      hold_served = hold_asks;
      hold_left   = 60;
    end
    if (out_xfer) stall_left = $urandom_range(0, stall_max);
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    out_xfer <= rst_n && out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      got.ev  = event_t'(out_event_res);
      got.cnt = out_byte_count;
      got.b1  = out_byte_one;
      got.b2  = out_byte_two;
      got.b3  = out_byte_three;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result ev=%0d cnt=%0d bytes=%h %h %h", $time,
                 got.ev, got.cnt, got.b1, got.b2, got.b3);
      end else begin
        want = awaited_results.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected ev=%0d cnt=%0d bytes=%h %h %h", $time,
                   want.ev, want.cnt, want.b1, want.b2, want.b3);
          $display("%0t:          actual   ev=%0d cnt=%0d bytes=%h %h %h", $time,
                   got.ev, got.cnt, got.b1, got.b2, got.b3);
        end
      end
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [3:0] cable();
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic push_packet(input logic [7:0] hdr, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3);
    packet_t p;
    p.hdr = hdr;
    p.b1  = b1;
    p.b2  = b2;
    p.b3  = b3;
    p.gap = $urandom_range(0, gap_max);
    packet_queue.push_back(p);
    items_pushed++;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (packet_queue.size() != 0 || staged || in_valid || awaited_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LenW-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic end_message(input bit corrupt);
    logic [7:0] last;
    last = corrupt ? rnd8() : MidiEox;
    case ($urandom_range(0, 3))
      0: push_packet({cable(), CinSysexEnd1}, last, rnd8(), rnd8());
      1: push_packet({cable(), CinSysexEnd2}, rnd8(), last, rnd8());
      2: push_packet({cable(), CinSysexEnd3}, rnd8(), rnd8(), last);
      default: push_packet({cable(), CinSingle}, last, rnd8(), rnd8());
    endcase
  endtask

  task automatic gen_message();
    int         kind;
    int         steps;
    logic [3:0] cin;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      push_packet({cable(), CinSysexCont}, MidiSox, rnd8(), rnd8());
      steps = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 4);
      repeat (steps) begin
        case ($urandom_range(0, 9))
          0, 1: push_packet({cable(), CinSingle}, 8'($urandom_range(0, 127)), rnd8(), rnd8());
          2: push_packet({cable(), CinSingle}, 8'($urandom_range(248, 255)), rnd8(), rnd8());
          3: push_packet({cable(), CinCtrlChg}, {MidiCcNibble, cable()}, rnd8(), rnd8());
          default: push_packet({cable(), CinSysexCont}, rnd8(), rnd8(), rnd8());
        endcase
      end
      end_message(1'b0);
    end else if (kind < 75) begin
      case ($urandom_range(0, 3))
        0: begin
          push_packet({cable(), CinSysexCont}, rnd8(), rnd8(), rnd8());
          repeat ($urandom_range(0, 2)) push_packet({cable(), CinSysexCont}, rnd8(), rnd8(), rnd8());
          end_message(1'b0);
        end
        1: begin
          push_packet({cable(), CinSysexCont}, MidiSox, rnd8(), rnd8());
          end_message(1'b1);
        end
        2: end_message(1'($urandom_range(0, 1)));
        default: begin
          push_packet({cable(), CinSysexCont}, MidiSox, rnd8(), rnd8());
          push_packet(rnd8(), rnd8(), rnd8(), rnd8());
          end_message(1'b0);
        end
      endcase
    end else if (kind < 88) begin
      case ($urandom_range(0, 2))
        0: push_packet({cable(), CinCtrlChg}, rnd8(), rnd8(), rnd8());
        1: push_packet({cable(), CinSingle}, rnd8(), rnd8(), rnd8());
        default: begin
          do cin = cable();
          while (cin inside {CinSysexCont, CinSysexEnd1, CinSysexEnd2, CinSysexEnd3,
                             CinCtrlChg, CinSingle});
          push_packet({cable(), cin}, rnd8(), rnd8(), rnd8());
        end
      endcase
    end else begin
      push_packet(rnd8(), rnd8(), rnd8(), rnd8());
    end
  endtask

  task automatic random_phase(input int unsigned n);
    int unsigned first;
    first = items_pushed;
    while (items_pushed - first < n) gen_message();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_packet({4'h0, CinSysexCont}, MidiSox, 8'h01, 8'h02);
    push_packet({4'hF, CinSysexCont}, 8'h03, 8'h04, 8'h05);
    push_packet({4'h3, CinSingle}, 8'h7F, 8'h00, 8'h00);
    push_packet({4'h0, CinSingle}, 8'hF8, 8'h00, 8'h00);
    push_packet({4'h0, CinSysexEnd3}, 8'h06, 8'h07, MidiEox);
    push_packet({4'h0, CinSysexCont}, MidiSox, 8'h11, 8'h22);
    push_packet({4'h0, CinSysexEnd2}, 8'h33, MidiEox, 8'h00);
    push_packet({4'h0, CinSysexCont}, MidiSox, 8'h00, 8'h00);
    push_packet({4'h0, CinSingle}, MidiEox, 8'hFF, 8'hFF);
    push_packet({4'h0, CinSysexEnd1}, MidiEox, 8'h00, 8'h00);
    push_packet({4'h0, CinSysexCont}, 8'h41, 8'h42, 8'h43);
    push_packet({4'h0, CinSysexEnd1}, MidiEox, 8'h00, 8'h00);
    push_packet({4'h0, CinSysexCont}, MidiSox, 8'h01, 8'h02);
    push_packet({4'h0, CinSysexEnd3}, 8'h01, 8'h02, 8'h03);
    push_packet({4'h0, CinSingle}, 8'h10, 8'h00, 8'h00);
    push_packet({4'h0, CinSingle}, MidiEox, 8'h00, 8'h00);
    push_packet({4'h0, CinCtrlChg}, 8'hB5, 8'h07, 8'h7F);
    push_packet({4'h0, CinCtrlChg}, 8'h90, 8'h40, 8'h40);
    push_packet(8'h00, 8'hFF, 8'hFF, 8'hFF);
    push_packet(8'hFA, 8'h80, 8'h00, 8'h00);
    push_packet(8'hFF, 8'hFF, 8'hFF, 8'hFF);

    write_limit(16'd4);
    push_packet({4'h0, CinSysexCont}, MidiSox, 8'h01, 8'h02);
    push_packet({4'h0, CinSysexCont}, 8'h03, 8'h04, 8'h05);
    push_packet({4'h0, CinSysexCont}, MidiSox, 8'h01, 8'h02);
    push_packet({4'h0, CinSingle}, 8'h01, 8'h00, 8'h00);
    push_packet({4'h0, CinSingle}, 8'h02, 8'h00, 8'h00);
    push_packet({4'h0, CinSysexCont}, MidiSox, 8'h01, 8'h02);
    push_packet({4'h0, CinSysexEnd3}, 8'h01, 8'h02, MidiEox);
    push_packet({4'h0, CinSysexCont}, MidiSox, 8'h01, 8'h02);
    push_packet({4'h0, CinSysexEnd1}, MidiEox, 8'h00, 8'h00);

    // lower the limit below the running count mid-message
    write_limit(16'd256);
    push_packet({4'h0, CinSysexCont}, MidiSox, 8'h01, 8'h02);
    push_packet({4'h0, CinSysexCont}, 8'h03, 8'h04, 8'h05);
    write_limit(16'd5);
    push_packet({4'h0, CinSysexCont}, 8'h06, 8'h07, 8'h08);

    write_limit(16'hFFFF);
    random_phase(75);
    write_limit(16'd12);
    random_phase(75);

    gap_max   = 0;
    stall_max = 0;
    write_limit(16'd256);
    random_phase(60);
    stall_max = 7;

    // hold the output while packets keep coming
    wait_idle();
    hold_asks++;
    random_phase(24);
    gap_max = 7;

    write_limit(16'd4);
    random_phase(60);
    write_limit(16'($urandom_range(4, 65535)));
    random_phase(70);
    write_limit(16'($urandom_range(4, 40)));
    random_phase(70);
    write_limit(16'd30);
    random_phase(70);

    wait_idle();
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
